### hw/rtl/kwsd_pkg.sv
`default_nettype none

package kwsd_pkg;

    localparam int KW_COUNT   = 10;
    localparam int WIN_LEN    = 7;
    localparam int HIST_DEPTH = 6;
    localparam int BYTE_W     = 8;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [KW_COUNT-1:0] t_hit;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd6, 3'd6, 3'd7, 3'd3, 3'd7, 3'd5, 3'd6, 3'd6, 3'd5
    };

    // Keywords are right-aligned in the seven-byte window; leading slots are padding.
    localparam t_byte KW_WIN [KW_COUNT][WIN_LEN] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, "n", "a", "v"},
        '{8'h00, "f", "o", "o", "t", "e", "r"},
        '{8'h00, "h", "e", "a", "d", "e", "r"},
        '{"s", "i", "d", "e", "b", "a", "r"},
        '{8'h00, 8'h00, 8'h00, 8'h00, "a", "d", "s"},
        '{"c", "o", "m", "m", "e", "n", "t"},
        '{8'h00, 8'h00, "p", "r", "o", "m", "o"},
        '{8'h00, "a", "d", "v", "e", "r", "t"},
        '{8'h00, "s", "o", "c", "i", "a", "l"},
        '{8'h00, 8'h00, "s", "h", "a", "r", "e"}
    };

    function automatic t_byte fold_case(input t_byte b);
        t_byte r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5a) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    function automatic t_hit column_match(input logic [2:0] pos, input t_byte b);
        t_hit h;
        for (int k = 0; k < KW_COUNT; k++) begin
            h[k] = ((4'(pos) + 4'(KW_LEN[k])) < 4'(WIN_LEN)) || (b == KW_WIN[k][pos]);
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/kwsd_cell.sv
`default_nettype none

module kwsd_cell #(
    parameter logic [2:0] POS = 3'd0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire kwsd_pkg::t_cell_ctl i_ctl,
    input  wire kwsd_pkg::t_byte     i_byte,
    output kwsd_pkg::t_byte          o_byte,
    output kwsd_pkg::t_hit           o_hit
);

    kwsd_pkg::t_byte r_byte;
    kwsd_pkg::t_byte n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = '0;
        end else if (i_ctl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = kwsd_pkg::column_match(POS, r_byte);

endmodule

`default_nettype wire

### hw/rtl/keyword_substring_detector_unit.sv
`default_nettype none

// Reports whether a byte string contains any of the keywords nav, footer, header,
// sidebar, ads, comment, promo, advert, social or share, ignoring ASCII case. One
// request carries one byte. A new request is taken every cycle unless a finished
// result is waiting on a stalled output, which holds the input stalled for as long.
// A row of six byte cells holds the recent folded bytes, and the whole seven-byte
// window is compared in the cycle the byte arrives. The request marked last yields
// one registered result in the next cycle and clears the window; a request without
// a byte and marked last closes the string, and an empty string gives zero.
module keyword_substring_detector_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_has_char,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_found
);

    localparam int DEPTH = kwsd_pkg::HIST_DEPTH;

    kwsd_pkg::t_byte     w_byte [DEPTH+1];
    kwsd_pkg::t_hit      w_hit  [DEPTH+1];
    kwsd_pkg::t_cell_ctl w_ctl;

    logic w_accept;
    logic w_match;
    logic r_seen;
    logic n_seen;
    logic r_valid;
    logic n_valid;
    logic r_found;
    logic n_found;

    assign o_stall  = r_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    assign w_ctl.shift = w_accept & i_has_char;
    assign w_ctl.clear = w_accept & i_last;

    assign w_byte[DEPTH] = kwsd_pkg::fold_case(i_ch);
    assign w_hit[DEPTH]  = kwsd_pkg::column_match(3'(DEPTH), w_byte[DEPTH]);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        kwsd_cell #(
            .POS (3'(g))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_byte  (w_byte[g+1]),
            .o_byte  (w_byte[g]),
            .o_hit   (w_hit[g])
        );
    end

    always_comb begin
        kwsd_pkg::t_hit all_hit;
        all_hit = '1;
        for (int p = 0; p <= DEPTH; p++) begin
            all_hit = all_hit & w_hit[p];
        end
        w_match = |all_hit;
    end

    always_comb begin
        n_seen  = r_seen;
        n_valid = r_valid & i_stall;
        n_found = r_found;
        if (w_accept) begin
            if (i_has_char && w_match) begin
                n_seen = 1'b1;
            end
            if (i_last) begin
                n_found = n_seen;
                n_valid = 1'b1;
                n_seen  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_seen  <= n_seen;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
    end

    assign o_valid = r_valid;
    assign o_found = r_found;

endmodule

`default_nettype wire

### hw/rtl/kwsd_checker.sv
`default_nettype none

module kwsd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       i_has_char,
    input wire logic       i_last,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_found
);

    logic w_in_acc;

    assign w_in_acc = i_valid && !o_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_found)))
        else $error("Result changed while stalled.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid && i_stall)) |-> $past(w_in_acc && i_last))
        else $error("Result without a closing request.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("Input stalled with no result waiting.");

    a_empty_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last) ##1 (w_in_acc && !i_has_char && i_last) |=> !o_found)
        else $error("Empty string reported a keyword.");

endmodule

bind keyword_substring_detector_unit kwsd_checker u_kwsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_has_char (i_has_char),
    .i_last     (i_last),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_found    (o_found)
);

`default_nettype wire
